@@ rtl/core/straight_path_vector_field_guidance_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the straight path guidance core.
// Checks vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STRAIGHT_PATH_VECTOR_FIELD_GUIDANCE_CORE_ASSERT_SVH
`define STRAIGHT_PATH_VECTOR_FIELD_GUIDANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check sampled on clk, switched off while reset is asserted.
`define SPVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check sampled on clk that also holds during reset.
`define SPVF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPVF_ASSERT(lbl, prop, msg)
`define SPVF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ rtl/core/spvf_pkg.sv @@
// ----------------------------------------------------------------------------
// spvf_pkg
// Widths, register indexes and types shared by the guidance core files.
// ----------------------------------------------------------------------------
`default_nettype none
package spvf_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int POS_FRAC       = 8;
    localparam int SPEED_W        = 16;
    localparam int VEL_W          = 17;
    localparam int VEL_MAX        = (1 << (VEL_W - 1)) - 1;
    localparam int RADIUS_W       = 31;
    localparam int RADIUS_RESET   = 1 << POS_FRAC;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd6;

    localparam int UNIT_W  = UNIT_FRAC_BITS + 2;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PRD_W   = DIFF_W + UNIT_W;
    localparam int ACC_W   = PRD_W + 2;
    localparam int ALN_W   = ACC_W - UNIT_FRAC_BITS + 1;
    localparam int PRJ_W   = ALN_W + UNIT_W;
    localparam int U3_IN_W = PRJ_W + 2;
    localparam int LP_W    = $clog2(U3_IN_W);
    localparam int DU_SHIFT = POS_FRAC + 1;
    localparam int GSQ_W   = 2 * RADIUS_W + 2;

    // Normalizer and root/divide datapath of the unit vector pipeline.
    localparam int NORM_W    = 30;
    localparam int NORM_TOP  = NORM_W - 1;
    localparam int SQ_W      = 2 * NORM_W + 2;
    localparam int SQ_STEPS  = NORM_W + 1;
    localparam int ROOT_W    = NORM_W + 1;
    localparam int DIV_STEPS = UNIT_FRAC_BITS + 1;
    localparam int QW        = DIV_STEPS;
    localparam int NUM_W     = NORM_W + UNIT_FRAC_BITS + 1;
    localparam int SQ_BASE   = 4;
    localparam int DV_BASE   = SQ_BASE + SQ_STEPS + 1;
    localparam int U3_LAT    = DV_BASE + DIV_STEPS + 2;

    localparam int TAG_W = SPEED_W + 1;

    localparam int DRAIN_CYC   = U3_LAT + 2;
    localparam int DRAIN_CNT_W = $clog2(DRAIN_CYC + 1);

    localparam int S_TDATA_W = ((3 * COORD_WIDTH + SPEED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * VEL_W + 1 + 7) / 8) * 8;

    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef logic signed [U3_IN_W-1:0] u3_in_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } u3_ctl_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DRAIN,
        SQ_FEED_LON,
        SQ_FEED_D,
        SQ_WAIT_LON,
        SQ_WAIT_DU,
        SQ_MUL,
        SQ_FEED_LAT,
        SQ_WAIT_LAT
    } seq_state_t;

endpackage
`default_nettype wire

@@ rtl/core/spvf_unit3.sv @@
// ----------------------------------------------------------------------------
// spvf_unit3
// Pipelined unit vector: normalize, sum of squares, one root bit per
// stage, one quotient bit per stage for the three components.
// ----------------------------------------------------------------------------
`default_nettype none
module spvf_unit3
    import spvf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire u3_ctl_t in_ctl,
    input  wire u3_in_t  in_vec [3],
    output u3_ctl_t      out_ctl,
    output unit_t        out_vec [3]
);

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [2:0]       neg;
        logic [TAG_W-1:0] tag;
    } side_t;

    side_t side_reg  [U3_LAT];
    side_t side_next [U3_LAT];

    logic [2:0][U3_IN_W-1:0] m1_reg, m2_reg, m1_next;
    logic [U3_IN_W-1:0]      big1_reg, big1_next;
    logic [LP_W-1:0]         lp2_reg, lp2_next;
    logic [2:0][NORM_W-1:0]  mn3_reg, mn3_next, mn4_reg;
    logic [2:0][2*NORM_W-1:0] sqr4_reg;

    logic [SQ_W-1:0]         sqs_reg [SQ_STEPS+1];
    logic [SQ_W-1:0]         sqr_reg [SQ_STEPS+1];
    logic [2:0][NORM_W-1:0]  sqm_reg [SQ_STEPS+1];
    logic [SQ_W-1:0]         sqs_next [SQ_STEPS+1];
    logic [SQ_W-1:0]         sqr_next [SQ_STEPS+1];

    logic [2:0][NUM_W-1:0]   dvr_reg [DIV_STEPS+1];
    logic [2:0][QW-1:0]      dvq_reg [DIV_STEPS+1];
    logic [ROOT_W-1:0]       dvn_reg [DIV_STEPS+1];
    logic [2:0][NUM_W-1:0]   dvr_next [DIV_STEPS+1];
    logic [2:0][QW-1:0]      dvq_next [DIV_STEPS+1];

    unit_t out_vec_reg [3];

    // Side band: sign bits enter with the item, the zero flag joins once
    // the largest magnitude is known.
    always_comb
    begin
        for (int i = 0; i < U3_LAT; i++) begin
            side_next[i] = (i == 0) ? side_reg[0] : side_reg[i-1];
        end
        side_next[0].valid = in_ctl.valid;
        side_next[0].tag   = in_ctl.tag;
        side_next[0].zero  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            side_next[0].neg[i] = in_vec[i][U3_IN_W-1];
        end
        side_next[1].zero = (big1_reg == '0);
    end

    always_comb
    begin
        big1_next = '0;
        for (int i = 0; i < 3; i++) begin
            m1_next[i] = in_vec[i][U3_IN_W-1] ? U3_IN_W'(-in_vec[i]) : U3_IN_W'(in_vec[i]);
        end
        for (int i = 0; i < 3; i++) begin
            if (m1_next[i] > big1_next) begin
                big1_next = m1_next[i];
            end
        end
        lp2_next = '0;
        for (int i = 0; i < U3_IN_W; i++) begin
            if (big1_reg[i]) begin
                lp2_next = LP_W'(i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (lp2_reg <= LP_W'(NORM_TOP)) begin
                mn3_next[i] = NORM_W'(m2_reg[i] << (LP_W'(NORM_TOP) - lp2_reg));
            end else begin
                mn3_next[i] = NORM_W'(m2_reg[i] >> (lp2_reg - LP_W'(NORM_TOP)));
            end
        end
    end

    // Square root, one result bit per stage.
    always_comb
    begin
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        sqs_next[0] = SQ_W'(sqr4_reg[0]) + SQ_W'(sqr4_reg[1]) + SQ_W'(sqr4_reg[2]);
        sqr_next[0] = '0;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            trial = sqr_reg[k] + bitv;
            if (sqs_reg[k] >= trial) begin
                sqs_next[k+1] = sqs_reg[k] - trial;
                sqr_next[k+1] = (sqr_reg[k] >> 1) + bitv;
            end else begin
                sqs_next[k+1] = sqs_reg[k];
                sqr_next[k+1] = sqr_reg[k] >> 1;
            end
        end
    end

    // Restoring division, one quotient bit per stage, rounded half up.
    always_comb
    begin
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  dvs;
        root = ROOT_W'(sqr_reg[SQ_STEPS]);
        for (int c = 0; c < 3; c++) begin
            dvr_next[0][c] = (NUM_W'(sqm_reg[SQ_STEPS][c]) << UNIT_FRAC_BITS)
                           + NUM_W'(root >> 1);
            dvq_next[0][c] = '0;
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            dvs = NUM_W'(dvn_reg[j]) << (DIV_STEPS - 1 - j);
            for (int c = 0; c < 3; c++) begin
                if (dvr_reg[j][c] >= dvs) begin
                    dvr_next[j+1][c] = dvr_reg[j][c] - dvs;
                    dvq_next[j+1][c] = dvq_reg[j][c] | (QW'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    dvr_next[j+1][c] = dvr_reg[j][c];
                    dvq_next[j+1][c] = dvq_reg[j][c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < U3_LAT; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            for (int i = 0; i < U3_LAT; i++) begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            m1_reg   <= m1_next;
            big1_reg <= big1_next;
            m2_reg   <= m1_reg;
            lp2_reg  <= lp2_next;
            mn3_reg  <= mn3_next;
            mn4_reg  <= mn3_reg;
            for (int c = 0; c < 3; c++) begin
                sqr4_reg[c] <= mn3_reg[c] * mn3_reg[c];
            end
            sqm_reg[0] <= mn4_reg;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                sqs_reg[k] <= sqs_next[k];
                sqr_reg[k] <= sqr_next[k];
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                sqm_reg[k+1] <= sqm_reg[k];
            end
            dvn_reg[0] <= ROOT_W'(sqr_reg[SQ_STEPS]);
            for (int j = 0; j < DIV_STEPS; j++) begin
                dvn_reg[j+1] <= dvn_reg[j];
            end
            for (int j = 0; j <= DIV_STEPS; j++) begin
                dvr_reg[j] <= dvr_next[j];
                dvq_reg[j] <= dvq_next[j];
            end
            for (int c = 0; c < 3; c++) begin
                if (side_reg[U3_LAT-2].zero) begin
                    out_vec_reg[c] <= '0;
                end else if (side_reg[U3_LAT-2].neg[c]) begin
                    out_vec_reg[c] <= -UNIT_W'(dvq_reg[DIV_STEPS][c]);
                end else begin
                    out_vec_reg[c] <= UNIT_W'(dvq_reg[DIV_STEPS][c]);
                end
            end
        end
    end

    assign out_ctl.valid = side_reg[U3_LAT-1].valid;
    assign out_ctl.tag   = side_reg[U3_LAT-1].tag;
    assign out_vec       = out_vec_reg;

endmodule
`default_nettype wire

@@ rtl/core/straight_path_vector_field_guidance_core.sv @@
// ----------------------------------------------------------------------------
// straight_path_vector_field_guidance_core
// Vector field guidance along a straight segment from start to goal.
// ----------------------------------------------------------------------------
// Usage:
// An item on the slave stream carries a vehicle position and a commanded
// speed. For each item the master stream returns one item with the
// commanded velocity vector and the arrival flag. Items are independent.
// The segment and arrival radius come through the write port. After every
// register write the core rebuilds its path frame (the along-path unit
// vector and the two cross-path unit vectors) through its own unit
// vector pipeline; s_axis_tready stays low until the frame is rebuilt.
// From acceptance to m_axis_tvalid an item passes six datapath stages,
// 53 stages of the unit vector pipeline (normalize, 31 root steps,
// 15 quotient steps), one scaling stage and the output register.
// Throughput is one item per cycle. When m_axis_tready is low with a
// result waiting, the whole pipeline holds, and s_axis_tready falls with
// it. Reset empties the pipeline, loads start and goal at zero and the
// radius at one metre, and the core accepts items at once.
// ----------------------------------------------------------------------------
`default_nettype none
module straight_path_vector_field_guidance_core
    import spvf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Lowest bit up: pos_x, pos_y, pos_z, speed.
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Lowest bit up: vel_x, vel_y, vel_z, arrived, zero fill.
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "straight_path_vector_field_guidance_core_assert.svh"

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0] start_reg [3];
    logic signed [COORD_WIDTH-1:0] goal_reg  [3];
    logic [RADIUS_W-1:0]           radius_reg;

    // Path frame derived from the configuration.
    logic signed [DIFF_W-1:0] d_reg [3];
    unit_t                    lon_reg [3];
    unit_t                    lat_reg [3];
    unit_t                    du_reg  [3];
    logic [2*RADIUS_W-1:0]    r2_reg;
    logic signed [PRD_W-1:0]  latm_reg [4];

    seq_state_t             seq_reg, seq_next;
    logic [DRAIN_CNT_W-1:0] drain_reg, drain_next;
    u3_in_t                 u3c_vec_reg [3];
    u3_in_t                 u3c_vec_next [3];
    logic                   u3c_vld_reg, u3c_vld_next;
    logic                   cap_lon, cap_du, cap_lat, do_mul;
    u3_ctl_t                u3c_in_ctl, u3c_out_ctl;
    unit_t                  u3c_out_vec [3];

    // Per item pipeline.
    logic adv;
    logic accept;

    logic signed [COORD_WIDTH-1:0] pos [3];
    logic [SPEED_W-1:0]            speed_in;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [SPEED_W-1:0]       sp1_reg, sp2_reg, sp3_reg, sp4_reg, sp5_reg, sp6_reg;
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] g1_reg [3];

    logic signed [PRD_W-1:0]  pel2_reg [3];
    logic signed [PRD_W-1:0]  pet2_reg [3];
    logic signed [PRD_W-1:0]  pdg2_reg [3];
    logic [2*RADIUS_W-1:0]    gsq2_reg [3];
    logic                     far2_reg;

    logic signed [ACC_W-1:0]  alon3_reg, alat3_reg, pd3_reg;
    logic [GSQ_W-1:0]         gsum3_reg;
    logic                     far3_reg;

    logic signed [ALN_W-1:0]  alon4_reg, alat4_reg;
    logic                     arr4_reg, arr5_reg, arr6_reg, arr7_reg;

    logic signed [PRJ_W-1:0]  pa5_reg [3];
    logic signed [PRJ_W-1:0]  pb5_reg [3];
    u3_in_t                   u2_6_reg [3];

    u3_ctl_t                  u3p_in_ctl, u3p_out_ctl;
    unit_t                    uu_vec [3];

    logic signed [SPEED_W+UNIT_W:0] sv7_reg [3];

    logic signed [VEL_W-1:0]  vel_reg [3];
    logic                     arrived_reg;
    logic                     out_valid_reg;

    // Combinational helpers.
    logic [DIFF_W-1:0]        gmag [3];
    logic [ACC_W:0]           alon_m, alat_m;
    logic [ACC_W:0]           alon_r, alat_r;
    logic [SPEED_W+UNIT_W:0]  vmag [3];
    logic [SPEED_W+UNIT_W:0]  vrnd [3];
    logic signed [VEL_W-1:0]  vel_next [3];

    // ------------------------------------------------------------------
    // Configuration writes. Indexes past the radius are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                goal_reg[i]  <= '0;
            end
            radius_reg <= RADIUS_W'(RADIUS_RESET);
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_START_X: start_reg[0] <= cfg_wdata;
                REG_START_Y: start_reg[1] <= cfg_wdata;
                REG_START_Z: start_reg[2] <= cfg_wdata;
                REG_GOAL_X:  goal_reg[0]  <= cfg_wdata;
                REG_GOAL_Y:  goal_reg[1]  <= cfg_wdata;
                REG_GOAL_Z:  goal_reg[2]  <= cfg_wdata;
                REG_RADIUS:  radius_reg   <= RADIUS_W'(cfg_wdata);
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame sequencer. A write first lets the unit vector pipeline drain,
    // then feeds lon = unit(z x d) and unit(d), then lat = unit(d x lon).
    // The z part of lon is always zero, which trims the cross product.
    // ------------------------------------------------------------------
    always_comb
    begin
        seq_next     = seq_reg;
        drain_next   = drain_reg;
        u3c_vld_next = 1'b0;
        u3c_vec_next = u3c_vec_reg;
        cap_lon      = 1'b0;
        cap_du       = 1'b0;
        cap_lat      = 1'b0;
        do_mul       = 1'b0;
        case (seq_reg)
            SQ_IDLE: ;
            SQ_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_CNT_W'(DRAIN_CYC - 1)) begin
                    seq_next = SQ_FEED_LON;
                end
            end
            SQ_FEED_LON:
            begin
                u3c_vld_next    = 1'b1;
                u3c_vec_next[0] = -U3_IN_W'(d_reg[1]);
                u3c_vec_next[1] = U3_IN_W'(d_reg[0]);
                u3c_vec_next[2] = '0;
                seq_next        = SQ_FEED_D;
            end
            SQ_FEED_D:
            begin
                u3c_vld_next = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    u3c_vec_next[i] = U3_IN_W'(d_reg[i]);
                end
                seq_next = SQ_WAIT_LON;
            end
            SQ_WAIT_LON:
            begin
                if (u3c_out_ctl.valid) begin
                    cap_lon  = 1'b1;
                    seq_next = SQ_WAIT_DU;
                end
            end
            SQ_WAIT_DU:
            begin
                if (u3c_out_ctl.valid) begin
                    cap_du   = 1'b1;
                    seq_next = SQ_MUL;
                end
            end
            SQ_MUL:
            begin
                do_mul   = 1'b1;
                seq_next = SQ_FEED_LAT;
            end
            SQ_FEED_LAT:
            begin
                u3c_vld_next    = 1'b1;
                u3c_vec_next[0] = -U3_IN_W'(latm_reg[0]);
                u3c_vec_next[1] = U3_IN_W'(latm_reg[1]);
                u3c_vec_next[2] = U3_IN_W'(latm_reg[2]) - U3_IN_W'(latm_reg[3]);
                seq_next        = SQ_WAIT_LAT;
            end
            SQ_WAIT_LAT:
            begin
                if (u3c_out_ctl.valid) begin
                    cap_lat  = 1'b1;
                    seq_next = SQ_IDLE;
                end
            end
            default: seq_next = SQ_IDLE;
        endcase
        if (cfg_wen) begin
            seq_next   = SQ_DRAIN;
            drain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg     <= SQ_IDLE;
            drain_reg   <= '0;
            u3c_vld_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            drain_reg   <= drain_next;
            u3c_vld_reg <= u3c_vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                lon_reg[i] <= '0;
                lat_reg[i] <= '0;
                du_reg[i]  <= '0;
                d_reg[i]   <= '0;
            end
            r2_reg <= (2*RADIUS_W)'(RADIUS_RESET) * (2*RADIUS_W)'(RADIUS_RESET);
        end else begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= DIFF_W'(goal_reg[i]) - DIFF_W'(start_reg[i]);
                if (cap_lon) begin
                    lon_reg[i] <= u3c_out_vec[i];
                end
                if (cap_du) begin
                    du_reg[i] <= u3c_out_vec[i];
                end
                if (cap_lat) begin
                    lat_reg[i] <= u3c_out_vec[i];
                end
            end
            if (do_mul) begin
                r2_reg <= (2*RADIUS_W)'(radius_reg) * (2*RADIUS_W)'(radius_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u3c_vec_reg <= u3c_vec_next;
        if (do_mul) begin
            latm_reg[0] <= d_reg[2] * lon_reg[1];
            latm_reg[1] <= d_reg[2] * lon_reg[0];
            latm_reg[2] <= d_reg[0] * lon_reg[1];
            latm_reg[3] <= d_reg[1] * lon_reg[0];
        end
    end

    assign u3c_in_ctl.valid = u3c_vld_reg;
    assign u3c_in_ctl.tag   = '0;

    spvf_unit3 u_frame_unit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (1'b1),
        .in_ctl  (u3c_in_ctl),
        .in_vec  (u3c_vec_reg),
        .out_ctl (u3c_out_ctl),
        .out_vec (u3c_out_vec)
    );

    // ------------------------------------------------------------------
    // Item pipeline. Every stage moves together; a waiting result holds
    // the whole pipe.
    // ------------------------------------------------------------------
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && (seq_reg == SQ_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos[0]   = s_axis_tdata[COORD_WIDTH-1:0];
    assign pos[1]   = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign pos[2]   = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign speed_in = s_axis_tdata[3*COORD_WIDTH+SPEED_W-1:3*COORD_WIDTH];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            gmag[i] = g1_reg[i][DIFF_W-1] ? DIFF_W'(-g1_reg[i]) : DIFF_W'(g1_reg[i]);
        end
        // Projections rounded half away from zero to Q.8.
        alon_m = alon3_reg[ACC_W-1] ? (ACC_W+1)'(-alon3_reg) : (ACC_W+1)'(alon3_reg);
        alat_m = alat3_reg[ACC_W-1] ? (ACC_W+1)'(-alat3_reg) : (ACC_W+1)'(alat3_reg);
        alon_r = (alon_m + (ACC_W+1)'(1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
        alat_r = (alat_m + (ACC_W+1)'(1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
        // Velocity scaling, rounding and saturation.
        for (int i = 0; i < 3; i++) begin
            vmag[i] = sv7_reg[i][SPEED_W+UNIT_W] ? (SPEED_W+UNIT_W+1)'(-sv7_reg[i])
                                                 : (SPEED_W+UNIT_W+1)'(sv7_reg[i]);
            vrnd[i] = (vmag[i] + (SPEED_W+UNIT_W+1)'(1 << (UNIT_FRAC_BITS - 1)))
                      >> UNIT_FRAC_BITS;
            if (vrnd[i] > (SPEED_W+UNIT_W+1)'(VEL_MAX)) begin
                vrnd[i] = (SPEED_W+UNIT_W+1)'(VEL_MAX);
            end
            vel_next[i] = sv7_reg[i][SPEED_W+UNIT_W] ? -VEL_W'(vrnd[i]) : VEL_W'(vrnd[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= u3p_out_ctl.valid;
            out_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            // Errors from start and goal.
            sp1_reg <= speed_in;
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= DIFF_W'(pos[i]) - DIFF_W'(start_reg[i]);
                g1_reg[i] <= DIFF_W'(pos[i]) - DIFF_W'(goal_reg[i]);
            end
            // Products for both projections, the goal plane and the radius.
            sp2_reg  <= sp1_reg;
            far2_reg <= |gmag[0][DIFF_W-1:RADIUS_W] || |gmag[1][DIFF_W-1:RADIUS_W]
                     || |gmag[2][DIFF_W-1:RADIUS_W];
            for (int i = 0; i < 3; i++) begin
                pel2_reg[i] <= e1_reg[i] * lon_reg[i];
                pet2_reg[i] <= e1_reg[i] * lat_reg[i];
                pdg2_reg[i] <= g1_reg[i] * du_reg[i];
                gsq2_reg[i] <= gmag[i][RADIUS_W-1:0] * gmag[i][RADIUS_W-1:0];
            end
            // Sums.
            sp3_reg   <= sp2_reg;
            alon3_reg <= ACC_W'(pel2_reg[0]) + ACC_W'(pel2_reg[1]) + ACC_W'(pel2_reg[2]);
            alat3_reg <= ACC_W'(pet2_reg[0]) + ACC_W'(pet2_reg[1]) + ACC_W'(pet2_reg[2]);
            pd3_reg   <= ACC_W'(pdg2_reg[0]) + ACC_W'(pdg2_reg[1]) + ACC_W'(pdg2_reg[2]);
            gsum3_reg <= GSQ_W'(gsq2_reg[0]) + GSQ_W'(gsq2_reg[1]) + GSQ_W'(gsq2_reg[2]);
            far3_reg  <= far2_reg;
            // Rounded projections and the arrival decision.
            sp4_reg   <= sp3_reg;
            alon4_reg <= alon3_reg[ACC_W-1] ? -ALN_W'(alon_r) : ALN_W'(alon_r);
            alat4_reg <= alat3_reg[ACC_W-1] ? -ALN_W'(alat_r) : ALN_W'(alat_r);
            arr4_reg  <= !pd3_reg[ACC_W-1]
                      || (!far3_reg && (gsum3_reg < GSQ_W'(r2_reg)));
            // Projection back onto the frame.
            sp5_reg  <= sp4_reg;
            arr5_reg <= arr4_reg;
            for (int i = 0; i < 3; i++) begin
                pa5_reg[i] <= alon4_reg * lon_reg[i];
                pb5_reg[i] <= alat4_reg * lat_reg[i];
            end
            // Twice the steering vector: -proj + 2 * unit(d) at Q.22.
            sp6_reg  <= sp5_reg;
            arr6_reg <= arr5_reg;
            for (int i = 0; i < 3; i++) begin
                u2_6_reg[i] <= (U3_IN_W'(du_reg[i]) <<< DU_SHIFT)
                             - U3_IN_W'(pa5_reg[i]) - U3_IN_W'(pb5_reg[i]);
            end
            // Scale the unit steering vector by the speed.
            arr7_reg <= u3p_out_ctl.tag[SPEED_W];
            for (int i = 0; i < 3; i++) begin
                sv7_reg[i] <= $signed({1'b0, u3p_out_ctl.tag[SPEED_W-1:0]}) * uu_vec[i];
            end
            arrived_reg <= arr7_reg;
            for (int i = 0; i < 3; i++) begin
                vel_reg[i] <= vel_next[i];
            end
        end
    end

    assign u3p_in_ctl.valid = v6_reg;
    assign u3p_in_ctl.tag   = {arr6_reg, sp6_reg};

    spvf_unit3 u_steer_unit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (u3p_in_ctl),
        .in_vec  (u2_6_reg),
        .out_ctl (u3p_out_ctl),
        .out_vec (uu_vec)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - 3*VEL_W - 1)'(0), arrived_reg,
                            vel_reg[2], vel_reg[1], vel_reg[0]};

    // A register write takes the input side down for the frame rebuild.
    `SPVF_ASSERT(a_cfg_blocks_input, cfg_wen |=> !s_axis_tready, "input open during frame rebuild")
    // Saturation keeps every velocity inside plus or minus VEL_MAX.
    `SPVF_ASSERT(a_vel_saturated, m_axis_tvalid |-> (vel_reg[0] != -(VEL_W'(VEL_MAX) + 1'b1) && vel_reg[1] != -(VEL_W'(VEL_MAX) + 1'b1) && vel_reg[2] != -(VEL_W'(VEL_MAX) + 1'b1)), "velocity outside saturation range")
    // Reset empties the output stage.
    `SPVF_ASSERT_NR(a_reset_empty, !rst_n |-> !m_axis_tvalid, "result valid during reset")
    // The drain always hands over to the first frame feed.
    `SPVF_ASSERT(a_drain_exit, (seq_reg == SQ_DRAIN) |=> (seq_reg == SQ_DRAIN || seq_reg == SQ_FEED_LON), "sequencer left drain early")

endmodule
`default_nettype wire
